### design/vlpci_pkg.sv
// Shared types, codes and constants of the legacy virtio PCI register block.
// No dependencies; vlpci_ring_calc and the top level refer to this package by scoped names.
package vlpci_pkg;

  localparam int unsigned MaxQueuesDef = 4;
  localparam int unsigned AddrW        = 44;
  localparam int unsigned PageShift    = 12;
  localparam int unsigned PageBytes    = 4096;
  localparam logic [31:0] AllOnes      = 32'hffff_ffff;

  // operation codes
  localparam logic [1:0] OpRead     = 2'd0;
  localparam logic [1:0] OpWrite    = 2'd1;
  localparam logic [1:0] OpComplete = 2'd2;

  // access width codes
  localparam logic [1:0] WidthByte = 2'd0;
  localparam logic [1:0] WidthHalf = 2'd1;
  localparam logic [1:0] WidthWord = 2'd2;

  // header offsets
  localparam logic [7:0] OffDevFeat   = 8'd0;
  localparam logic [7:0] OffGuestFeat = 8'd4;
  localparam logic [7:0] OffQueuePage = 8'd8;
  localparam logic [7:0] OffQueueSize = 8'd12;
  localparam logic [7:0] OffQueueSel  = 8'd14;
  localparam logic [7:0] OffNotify    = 8'd16;
  localparam logic [7:0] OffStatus    = 8'd18;
  localparam logic [7:0] OffIsr       = 8'd19;

  // configuration register indexes
  localparam logic [1:0] CfgDevFeat   = 2'd0;
  localparam logic [1:0] CfgNumQueues = 2'd1;
  localparam logic [1:0] CfgRingSize  = 2'd2;
  localparam logic [1:0] CfgIoSize    = 2'd3;

  // configuration reset values
  localparam logic [31:0] DevFeatRst   = 32'd0;
  localparam logic [2:0]  NumQueuesRst = 3'd1;
  localparam logic [15:0] RingSizeRst  = 16'd256;
  localparam logic [7:0]  IoSizeRst    = 8'd20;

  typedef struct packed {
    logic [AddrW-1:0] desc;
    logic [AddrW-1:0] avail;
    logic [AddrW-1:0] used;
  } ring_addr_t;

endpackage

### design/vlpci_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vlpci_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/vlpci_qtable.sv
// Queue page table: RAM plus per-entry valid bits (unwritten entries read zero)
// and a write-to-read bypass. Depends on vlpci_ram.
module vlpci_qtable #(
  parameter int unsigned MaxQueues = 4,
  localparam int unsigned Qw = (MaxQueues > 1) ? $clog2(MaxQueues) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [Qw-1:0] raddr_i,
  input  logic          we_i,
  input  logic [Qw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [MaxQueues-1:0] valid_q, valid_d;
  logic                 rd_valid_q;
  logic                 byp_hit_q;
  logic [31:0]          byp_data_q;
  logic [31:0]          ram_rdata;

  vlpci_ram #(
    .Width(32),
    .Depth(MaxQueues)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= valid_q[raddr_i];
      byp_hit_q  <= we_i && (waddr_i == raddr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata_i;
  end

  // a write in the same cycle as the read wins over the stale RAM word
  assign rdata_o = byp_hit_q  ? byp_data_q :
                   rd_valid_q ? ram_rdata  : 32'd0;

endmodule

### design/vlpci_ring_calc.sv
// Ring layout arithmetic: descriptor, available and used ring addresses.
// Depends on vlpci_pkg.
module vlpci_ring_calc (
  input  logic [31:0]             page_i,
  input  logic [15:0]             ring_size_i,
  output vlpci_pkg::ring_addr_t   addr_o
);

  localparam int unsigned AddrW = vlpci_pkg::AddrW;
  localparam int unsigned Ps    = vlpci_pkg::PageShift;

  logic [20:0] span;
  logic [20:0] span_rnd;
  logic [8:0]  span_pages;

  // used ring starts at the first page boundary at least 18 bytes per entry plus 4 past the base
  assign span       = 21'(ring_size_i) * 21'd18 + 21'd4;
  assign span_rnd   = span + 21'(vlpci_pkg::PageBytes - 1);
  assign span_pages = span_rnd[20:Ps];

  assign addr_o.desc  = {page_i, {Ps{1'b0}}};
  assign addr_o.avail = addr_o.desc + AddrW'({ring_size_i, 4'b0000});
  assign addr_o.used  = {page_i + 32'(span_pages), {Ps{1'b0}}};

endmodule

### design/virtio_legacy_pci_register_file_unit.sv
// Legacy virtio PCI register block, top level.
// A transaction passes through the input register and the result register; its result
// is on the outputs, with done_o high, once the result register has captured it.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// Reset: asynchronous, active low; clears all header state and the queue table
// valid bits, and loads the configuration registers with their defaults.
module virtio_legacy_pci_register_file_unit #(
  parameter int unsigned MaxQueues = vlpci_pkg::MaxQueuesDef,
  localparam int unsigned Qw = (MaxQueues > 1) ? $clog2(MaxQueues) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // transaction port
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  offset_i,
  input  logic [1:0]  width_i,
  input  logic [31:0] wdata_i,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // result port
  output logic        done_o,
  output logic [31:0] rdata_o,
  output logic        notify_valid_o,
  output logic [7:0]  notify_queue_o,
  output logic        irq_pulse_o,
  output logic        ring_set_o,
  output logic [43:0] desc_addr_o,
  output logic [43:0] avail_addr_o,
  output logic [43:0] used_addr_o
);

  localparam int unsigned AddrW = vlpci_pkg::AddrW;

  // Queue q is usable below both the configured count and the table depth.
  function automatic logic q_usable(logic [15:0] q, logic [2:0] nq);
    return (q < 16'(nq)) && (32'(q) < MaxQueues);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] dev_feat_q;
  logic [2:0]  num_queues_q;
  logic [15:0] ring_size_q;
  logic [7:0]  io_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_feat_q   <= vlpci_pkg::DevFeatRst;
      num_queues_q <= vlpci_pkg::NumQueuesRst;
      ring_size_q  <= vlpci_pkg::RingSizeRst;
      io_size_q    <= vlpci_pkg::IoSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vlpci_pkg::CfgDevFeat:   dev_feat_q   <= cfg_wdata_i;
        vlpci_pkg::CfgNumQueues: num_queues_q <= cfg_wdata_i[2:0];
        vlpci_pkg::CfgRingSize:  ring_size_q  <= cfg_wdata_i[15:0];
        vlpci_pkg::CfgIoSize:    io_size_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: capture every accepted transaction; never stall
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        s_valid_q;
  logic [1:0]  s_op_q;
  logic [7:0]  s_off_q;
  logic [1:0]  s_width_q;
  logic [31:0] s_wdata_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_op_q    <= op_i;
      s_off_q   <= offset_i;
      s_width_q <= width_i;
      s_wdata_q <= wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Header state
  // ---------------------------------------------------------------------------
  logic [31:0] guest_feat_q, guest_feat_d;
  logic [15:0] sel_queue_q, sel_queue_d;
  logic [31:0] addr_shadow_q, addr_shadow_d;
  logic [15:0] size_shadow_q, size_shadow_d;
  logic [15:0] last_notify_q, last_notify_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  isr_q, isr_d;

  // Queue page table. The page for a queue select is read while the
  // transaction sits at the input port, so it is ready once the input register holds it.
  logic          qt_we;
  logic [Qw-1:0] qt_waddr;
  logic [31:0]   qt_rdata;

  vlpci_qtable #(
    .MaxQueues(MaxQueues)
  ) u_qtable (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raddr_i(wdata_i[Qw-1:0]),
    .we_i   (qt_we),
    .waddr_i(qt_waddr),
    .wdata_i(s_wdata_q),
    .rdata_o(qt_rdata)
  );

  vlpci_pkg::ring_addr_t ring_addr;

  vlpci_ring_calc u_ring_calc (
    .page_i     (s_wdata_q),
    .ring_size_i(ring_size_q),
    .addr_o     (ring_addr)
  );

  // ---------------------------------------------------------------------------
  // Decode and execute
  // ---------------------------------------------------------------------------
  logic        in_region;
  logic [7:0]  room;
  logic        fits;
  logic        is_word, is_half, is_byte;
  logic [31:0] rdata_d;
  logic        nvalid_d;
  logic [7:0]  nqueue_d;
  logic        irq_d;
  logic        rset_d;

  assign in_region = s_off_q < io_size_q;
  assign room      = io_size_q - s_off_q;
  assign is_word   = s_width_q == vlpci_pkg::WidthWord;
  assign is_half   = s_width_q == vlpci_pkg::WidthHalf;
  assign is_byte   = s_width_q == vlpci_pkg::WidthByte;
  // width code three never fits
  assign fits      = is_byte || (is_half && room > 8'd1) || (is_word && room > 8'd3);

  assign qt_waddr = sel_queue_q[Qw-1:0];

  always_comb begin
    guest_feat_d  = guest_feat_q;
    sel_queue_d   = sel_queue_q;
    addr_shadow_d = addr_shadow_q;
    size_shadow_d = size_shadow_q;
    last_notify_d = last_notify_q;
    status_d      = status_q;
    isr_d         = isr_q;
    qt_we         = 1'b0;
    rdata_d       = 32'd0;
    nvalid_d      = 1'b0;
    nqueue_d      = 8'd0;
    irq_d         = 1'b0;
    rset_d        = 1'b0;

    if (s_valid_q) begin
      if (s_op_q == vlpci_pkg::OpComplete) begin
        isr_d = isr_q | 8'd1;
        irq_d = 1'b1;
      end else if (s_op_q == vlpci_pkg::OpRead && in_region) begin
        priority if (is_word && s_off_q == vlpci_pkg::OffDevFeat) begin
          rdata_d = dev_feat_q;
        end else if (is_word && s_off_q == vlpci_pkg::OffGuestFeat) begin
          rdata_d = guest_feat_q;
        end else if (is_word && s_off_q == vlpci_pkg::OffQueuePage) begin
          rdata_d = addr_shadow_q;
        end else if (is_half && s_off_q == vlpci_pkg::OffQueueSize) begin
          rdata_d = 32'(size_shadow_q);
        end else if (is_half && s_off_q == vlpci_pkg::OffQueueSel) begin
          rdata_d = 32'(sel_queue_q);
        end else if (is_half && s_off_q == vlpci_pkg::OffNotify) begin
          rdata_d = 32'(last_notify_q);
        end else if (is_byte && s_off_q == vlpci_pkg::OffStatus) begin
          rdata_d = 32'(status_q);
        end else if (is_byte && s_off_q == vlpci_pkg::OffIsr) begin
          rdata_d = 32'(isr_q);
        end else begin
          rdata_d = fits ? 32'd0 : vlpci_pkg::AllOnes;
        end
      end else if (s_op_q == vlpci_pkg::OpWrite && in_region) begin
        if (is_word && s_off_q == vlpci_pkg::OffGuestFeat) begin
          guest_feat_d = s_wdata_q;
        end else if (is_word && s_off_q == vlpci_pkg::OffQueuePage) begin
          // store the page and report the ring layout for a usable queue only
          if (q_usable(sel_queue_q, num_queues_q)) begin
            qt_we  = 1'b1;
            rset_d = 1'b1;
          end
        end else if (is_half && s_off_q == vlpci_pkg::OffQueueSel) begin
          sel_queue_d = s_wdata_q[15:0];
          if (q_usable(s_wdata_q[15:0], num_queues_q)) begin
            addr_shadow_d = qt_rdata;
            size_shadow_d = ring_size_q;
          end else begin
            addr_shadow_d = 32'd0;
            size_shadow_d = 16'd0;
          end
        end else if (is_half && s_off_q == vlpci_pkg::OffNotify) begin
          last_notify_d = {8'd0, s_wdata_q[7:0]};
          if (q_usable({8'd0, s_wdata_q[7:0]}, num_queues_q)) begin
            nvalid_d = 1'b1;
            nqueue_d = s_wdata_q[7:0];
          end
        end else if (is_byte && s_off_q == vlpci_pkg::OffStatus) begin
          status_d = s_wdata_q[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guest_feat_q  <= 32'd0;
      sel_queue_q   <= 16'd0;
      addr_shadow_q <= 32'd0;
      size_shadow_q <= 16'd0;
      last_notify_q <= 16'd0;
      status_q      <= 8'd0;
      isr_q         <= 8'd0;
    end else begin
      guest_feat_q  <= guest_feat_d;
      sel_queue_q   <= sel_queue_d;
      addr_shadow_q <= addr_shadow_d;
      size_shadow_q <= size_shadow_d;
      last_notify_q <= last_notify_d;
      status_q      <= status_d;
      isr_q         <= isr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one strobe per transaction
  // ---------------------------------------------------------------------------
  logic             done_q;
  logic [31:0]      rdata_q;
  logic             nvalid_q;
  logic [7:0]       nqueue_q;
  logic             irq_q;
  logic             rset_q;
  logic [AddrW-1:0] desc_q, avail_q, used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q  <= rdata_d;
    nvalid_q <= nvalid_d;
    nqueue_q <= nqueue_d;
    irq_q    <= irq_d;
    rset_q   <= rset_d;
    // addresses read zero unless a ring was set up
    desc_q   <= rset_d ? ring_addr.desc  : '0;
    avail_q  <= rset_d ? ring_addr.avail : '0;
    used_q   <= rset_d ? ring_addr.used  : '0;
  end

  assign done_o         = done_q;
  assign rdata_o        = rdata_q;
  assign notify_valid_o = nvalid_q;
  assign notify_queue_o = nqueue_q;
  assign irq_pulse_o    = irq_q;
  assign ring_set_o     = rset_q;
  assign desc_addr_o    = desc_q;
  assign avail_addr_o   = avail_q;
  assign used_addr_o    = used_q;

endmodule
